@@ src/grid_ray_traversal_dda_top_macros.svh @@
// assertion macros used by the grid ray traversal controller
`ifndef GRID_RAY_TRAVERSAL_DDA_TOP_MACROS_SVH
`define GRID_RAY_TRAVERSAL_DDA_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define GRT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define GRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/grt_pkg.sv @@
// types, constants and command codes of the grid ray traversal block
package grt_pkg;

   localparam int MAP_DIM   = 64;
   localparam int FRAC_BITS = 16;

   localparam int CELL_W  = $clog2(MAP_DIM);
   localparam int ADDR_W  = 2 * CELL_W;
   localparam int MPOS_W  = CELL_W + 2;
   localparam int TILE_W  = 9;
   localparam int POS_W   = 22;
   localparam int DIR_W   = 18;
   localparam int MAG_W   = DIR_W;
   localparam int CFG_W   = 7;
   localparam int DIST_W  = 24;
   localparam int WALL_W  = 16;
   localparam int FX_W    = FRAC_BITS + 1;
   localparam int NUM_W   = CELL_W + FRAC_BITS + 2;
   localparam int SIDE_W  = NUM_W + MAG_W;
   localparam int PROD_W  = NUM_W + 1 + DIR_W;
   localparam int DIV_W   = SIDE_W;
   localparam int HIT_W   = CELL_W + FRAC_BITS + 1;
   localparam int SQ_W    = 2 * HIT_W;
   localparam int ROOT_W  = SQ_W / 2 + 1;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int SREM_W  = ROOT_W + 2;

   localparam int DIV_STEPS  = DIV_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 2'd1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CAST = 1'b1;

   localparam logic [1:0] FACE_N = 2'd0;
   localparam logic [1:0] FACE_S = 2'd1;
   localparam logic [1:0] FACE_E = 2'd2;
   localparam logic [1:0] FACE_W = 2'd3;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [WALL_W-1:0] WALL_MAX = '1;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_INIT,
      CMD_SIDEX,
      CMD_SIDEY,
      CMD_STEP,
      CMD_CHECK,
      CMD_DIV_PERP,
      CMD_DIV_ITER,
      CMD_PERP_DONE,
      CMD_MUL,
      CMD_DIV_COORD,
      CMD_COORD_DONE,
      CMD_EXY,
      CMD_SQX,
      CMD_SQY,
      CMD_SQRT_ITER,
      CMD_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      tile_wr;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic oob;
      logic hit;
   } dp_stat_type;

endpackage

@@ src/grt_if.sv @@
// request, response and register write channel interfaces
interface grt_req_if;
   import grt_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    operation;
   logic [CELL_W-1:0]       tile_x;
   logic [CELL_W-1:0]       tile_y;
   logic [TILE_W-1:0]       tile_bits;
   logic [POS_W-1:0]        start_x;
   logic [POS_W-1:0]        start_y;
   logic signed [DIR_W-1:0] dir_x;
   logic signed [DIR_W-1:0] dir_y;
   logic                    hit_mode;

   modport source (output valid, operation, tile_x, tile_y, tile_bits, start_x, start_y,
                   dir_x, dir_y, hit_mode, input ready);
   modport sink (input valid, operation, tile_x, tile_y, tile_bits, start_x, start_y,
                 dir_x, dir_y, hit_mode, output ready);
endinterface

interface grt_rsp_if;
   import grt_pkg::*;
   logic              valid;
   logic              ready;
   logic              out_of_bounds;
   logic [1:0]        hit_face;
   logic [CELL_W-1:0] cell_x;
   logic [CELL_W-1:0] cell_y;
   logic [TILE_W-1:0] hit_tile_bits;
   logic [DIST_W-1:0] perp_distance;
   logic [WALL_W-1:0] wall_fraction;
   logic [DIST_W-1:0] euclid_distance;

   modport source (output valid, out_of_bounds, hit_face, cell_x, cell_y, hit_tile_bits,
                   perp_distance, wall_fraction, euclid_distance, input ready);
   modport sink (input valid, out_of_bounds, hit_face, cell_x, cell_y, hit_tile_bits,
                 perp_distance, wall_fraction, euclid_distance, output ready);
endinterface

interface grt_csr_if;
   import grt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/grt_ram.sv @@
// generic single write port ram with registered read
module grt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule

@@ src/grt_dp.sv @@
// datapath: tile store, dda stepping, shared divider, square root, result register
module grt_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  grt_pkg::dp_cmd_type              cmd,
   output grt_pkg::dp_stat_type             stat,
   input  logic [grt_pkg::CELL_W-1:0]       req_tile_x,
   input  logic [grt_pkg::CELL_W-1:0]       req_tile_y,
   input  logic [grt_pkg::TILE_W-1:0]       req_tile_bits,
   input  logic [grt_pkg::POS_W-1:0]        req_start_x,
   input  logic [grt_pkg::POS_W-1:0]        req_start_y,
   input  logic signed [grt_pkg::DIR_W-1:0] req_dir_x,
   input  logic signed [grt_pkg::DIR_W-1:0] req_dir_y,
   input  logic                             req_hit_mode,
   input  logic                             csr_wr,
   input  logic [grt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [grt_pkg::CFG_W-1:0]        csr_data,
   output logic                             rsp_out_of_bounds,
   output logic [1:0]                       rsp_hit_face,
   output logic [grt_pkg::CELL_W-1:0]       rsp_cell_x,
   output logic [grt_pkg::CELL_W-1:0]       rsp_cell_y,
   output logic [grt_pkg::TILE_W-1:0]       rsp_hit_tile_bits,
   output logic [grt_pkg::DIST_W-1:0]       rsp_perp_distance,
   output logic [grt_pkg::WALL_W-1:0]       rsp_wall_fraction,
   output logic [grt_pkg::DIST_W-1:0]       rsp_euclid_distance
);
   import grt_pkg::*;

   localparam logic [FX_W-1:0] FX_ONE = FX_W'(1) << FRAC_BITS;

   // clear sweep and map size registers
   logic [ADDR_W:0]   clr_addr_ff;
   logic [CFG_W-1:0]  map_w_ff, map_h_ff;
   logic [CFG_W-1:0]  w_eff, h_eff;
   logic              clearing;

   // ray registers
   logic [POS_W-1:0]        sx_ff, sy_ff;
   logic signed [DIR_W-1:0] dx_ff, dy_ff;
   logic [MAG_W-1:0]        adx_ff, ady_ff;
   logic                    mode_ff;
   logic signed [MPOS_W-1:0] mx_ff, my_ff;
   logic [NUM_W-1:0]        numx_ff, numy_ff, last_num_ff;
   logic [SIDE_W-1:0]       sidex_ff, sidey_ff;
   logic [1:0]              face_ff;
   logic                    xstep_ff;
   logic [TILE_W-1:0]       bits_ff;
   logic                    oob_ff;

   // finish registers
   logic [DIV_W-1:0]        dvd_ff;
   logic [MAG_W-1:0]        rem_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                    neg_ff;
   logic [DIST_W-1:0]       perp_ff;
   logic [FX_W-1:0]         wall_ff;
   logic [HIT_W-1:0]        ex_ff, ey_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic [RAD_W-1:0]        rad_ff;
   logic [SREM_W-1:0]       srem_ff;
   logic [ROOT_W-1:0]       root_ff;

   logic [TILE_W-1:0]       rdata;
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
   logic [TILE_W-1:0]       ram_wdata;

   // combinational helpers
   logic [FX_W-1:0]          frac_x, frac_y, fx, fy;
   logic                     take_x;
   logic signed [MPOS_W-1:0] nx, ny;
   logic                     stop_bit, tex_bit;
   logic [MAG_W-1:0]         den;
   logic signed [DIR_W-1:0]  comp;
   logic [POS_W-1:0]         base;
   logic [MAG_W:0]           rem_sh;
   logic                     div_ge;
   logic [FRAC_BITS-1:0]     fd16, coord_low;
   logic [HIT_W-1:0]         hx, hy;
   logic [SREM_W-1:0]        srem_sh, strial;
   logic                     sq_ge;
   logic [SQ_W-1:0]          sq_sum;

   assign clearing = !clr_addr_ff[ADDR_W];
   assign w_eff = (map_w_ff > CFG_W'(MAP_DIM)) ? CFG_W'(MAP_DIM) : map_w_ff;
   assign h_eff = (map_h_ff > CFG_W'(MAP_DIM)) ? CFG_W'(MAP_DIM) : map_h_ff;

   // tile store: cleared by a sweep after reset, written by load requests
   assign ram_we    = clearing || cmd.tile_wr;
   assign ram_waddr = clearing ? clr_addr_ff[ADDR_W-1:0] : {req_tile_y, req_tile_x};
   assign ram_wdata = clearing ? '0 : req_tile_bits;
   assign ram_raddr = {ny[CELL_W-1:0], nx[CELL_W-1:0]};

   grt_ram #(.WIDTH(TILE_W), .DEPTH(MAP_DIM * MAP_DIM)) u_tiles (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.op == CMD_STEP),
      .raddr (ram_raddr),
      .rdata (rdata)
   );

   // first boundary offsets from the start point
   always_comb begin
      frac_x = {1'b0, req_start_x[FRAC_BITS-1:0]};
      frac_y = {1'b0, req_start_y[FRAC_BITS-1:0]};
      fx = req_dir_x[DIR_W-1] ? frac_x : FX_ONE - frac_x;
      fy = req_dir_y[DIR_W-1] ? frac_y : FX_ONE - frac_y;
   end

   // dda choice: y step on a tie
   always_comb begin
      take_x = sidex_ff < sidey_ff;
      nx = mx_ff;
      ny = my_ff;
      if (take_x) begin
         nx = dx_ff[DIR_W-1] ? mx_ff - MPOS_W'(1) : mx_ff + MPOS_W'(1);
      end else begin
         ny = dy_ff[DIR_W-1] ? my_ff - MPOS_W'(1) : my_ff + MPOS_W'(1);
      end
   end

   // bounds and stop test on the tile just read
   always_comb begin
      stat.clear_done = !clearing;
      stat.oob = mx_ff[MPOS_W-1] || my_ff[MPOS_W-1]
              || (CFG_W'(mx_ff[MPOS_W-2:0]) >= w_eff)
              || (CFG_W'(my_ff[MPOS_W-2:0]) >= h_eff);
      stop_bit = rdata[0];
      tex_bit  = rdata[5];
      case (face_ff)
         FACE_N: begin
            stop_bit = mode_ff ? rdata[1] : rdata[0];
            tex_bit  = rdata[5];
         end
         FACE_S: begin
            stop_bit = mode_ff ? rdata[2] : rdata[0];
            tex_bit  = rdata[6];
         end
         FACE_E: begin
            stop_bit = mode_ff ? rdata[3] : rdata[0];
            tex_bit  = rdata[7];
         end
         default: begin
            stop_bit = mode_ff ? rdata[4] : rdata[0];
            tex_bit  = rdata[8];
         end
      endcase
      stat.hit = stop_bit && tex_bit;
   end

   // operands of the perpendicular and hit point divisions
   always_comb begin
      den  = xstep_ff ? adx_ff : ady_ff;
      comp = xstep_ff ? dy_ff : dx_ff;
      base = xstep_ff ? sy_ff : sx_ff;
      rem_sh = {rem_ff, dvd_ff[DIV_W-1]};
      div_ge = rem_sh >= {1'b0, den};
      fd16 = neg_ff ? FRAC_BITS'(-(dvd_ff[FRAC_BITS-1:0] + FRAC_BITS'(rem_ff != '0)))
                    : dvd_ff[FRAC_BITS-1:0];
      coord_low = (den == '0) ? base[FRAC_BITS-1:0] : base[FRAC_BITS-1:0] + fd16;
   end

   // hit point and square root step
   always_comb begin
      hx = {1'b0, mx_ff[CELL_W-1:0], {FRAC_BITS{1'b0}}};
      hy = {1'b0, my_ff[CELL_W-1:0], {FRAC_BITS{1'b0}}};
      if (xstep_ff) begin
         hy = hy + HIT_W'(wall_ff);
      end else begin
         hx = hx + HIT_W'(wall_ff);
      end
      srem_sh = {srem_ff[SREM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      strial  = {root_ff, 2'b01};
      sq_ge   = srem_sh >= strial;
      sq_sum  = sq_ff + SQ_W'(ey_ff) * SQ_W'(ey_ff);
   end

   // control registers: clear sweep and map size
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         map_w_ff    <= CFG_W'(MAP_DIM);
         map_h_ff    <= CFG_W'(MAP_DIM);
      end else begin
         if (clearing) begin
            clr_addr_ff <= clr_addr_ff + (ADDR_W+1)'(1);
         end
         if (csr_wr) begin
            unique case (csr_index)
               CSR_MAP_WIDTH:  map_w_ff <= csr_data;
               CSR_MAP_HEIGHT: map_h_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_INIT: begin
            sx_ff   <= req_start_x;
            sy_ff   <= req_start_y;
            dx_ff   <= req_dir_x;
            dy_ff   <= req_dir_y;
            adx_ff  <= req_dir_x[DIR_W-1] ? MAG_W'(-req_dir_x) : MAG_W'(req_dir_x);
            ady_ff  <= req_dir_y[DIR_W-1] ? MAG_W'(-req_dir_y) : MAG_W'(req_dir_y);
            mode_ff <= req_hit_mode;
            mx_ff   <= MPOS_W'(req_start_x[POS_W-1:FRAC_BITS]);
            my_ff   <= MPOS_W'(req_start_y[POS_W-1:FRAC_BITS]);
            numx_ff <= NUM_W'(fx);
            numy_ff <= NUM_W'(fy);
         end
         CMD_SIDEX: sidex_ff <= SIDE_W'(numx_ff) * SIDE_W'(ady_ff);
         CMD_SIDEY: sidey_ff <= SIDE_W'(numy_ff) * SIDE_W'(adx_ff);
         CMD_STEP: begin
            mx_ff <= nx;
            my_ff <= ny;
            if (take_x) begin
               last_num_ff <= numx_ff;
               numx_ff     <= numx_ff + NUM_W'(FX_ONE);
               sidex_ff    <= sidex_ff + SIDE_W'({ady_ff, {FRAC_BITS{1'b0}}});
               face_ff     <= dx_ff[DIR_W-1] ? FACE_N : FACE_S;
               xstep_ff    <= 1'b1;
            end else begin
               last_num_ff <= numy_ff;
               numy_ff     <= numy_ff + NUM_W'(FX_ONE);
               sidey_ff    <= sidey_ff + SIDE_W'({adx_ff, {FRAC_BITS{1'b0}}});
               face_ff     <= (!dy_ff[DIR_W-1] && dy_ff != '0) ? FACE_E : FACE_W;
               xstep_ff    <= 1'b0;
            end
         end
         CMD_CHECK: begin
            bits_ff <= rdata;
            oob_ff  <= stat.oob;
         end
         CMD_DIV_PERP: begin
            dvd_ff <= DIV_W'({last_num_ff, {FRAC_BITS{1'b0}}});
            rem_ff <= '0;
         end
         CMD_DIV_ITER: begin
            rem_ff <= div_ge ? MAG_W'(rem_sh - {1'b0, den}) : MAG_W'(rem_sh);
            dvd_ff <= {dvd_ff[DIV_W-2:0], div_ge};
         end
         CMD_PERP_DONE: begin
            if (den == '0) begin
               perp_ff <= '0;
            end else if (dvd_ff > DIV_W'(DIST_MAX)) begin
               perp_ff <= DIST_MAX;
            end else begin
               perp_ff <= dvd_ff[DIST_W-1:0];
            end
         end
         CMD_MUL: prod_ff <= $signed({1'b0, last_num_ff}) * comp;
         CMD_DIV_COORD: begin
            dvd_ff <= prod_ff[PROD_W-1] ? DIV_W'(-prod_ff) : DIV_W'(prod_ff);
            neg_ff <= prod_ff[PROD_W-1];
            rem_ff <= '0;
         end
         CMD_COORD_DONE: wall_ff <= FX_ONE - {1'b0, coord_low};
         CMD_EXY: begin
            ex_ff <= (hx >= HIT_W'(sx_ff)) ? hx - HIT_W'(sx_ff) : HIT_W'(sx_ff) - hx;
            ey_ff <= (hy >= HIT_W'(sy_ff)) ? hy - HIT_W'(sy_ff) : HIT_W'(sy_ff) - hy;
         end
         CMD_SQX: sq_ff <= SQ_W'(ex_ff) * SQ_W'(ex_ff);
         CMD_SQY: begin
            rad_ff  <= RAD_W'(sq_sum);
            srem_ff <= '0;
            root_ff <= '0;
         end
         CMD_SQRT_ITER: begin
            rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
            srem_ff <= sq_ge ? srem_sh - strial : srem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], sq_ge};
         end
         CMD_OUT: begin
            rsp_out_of_bounds <= oob_ff;
            rsp_hit_face      <= face_ff;
            if (oob_ff) begin
               rsp_cell_x          <= '0;
               rsp_cell_y          <= '0;
               rsp_hit_tile_bits   <= '0;
               rsp_perp_distance   <= '0;
               rsp_wall_fraction   <= '0;
               rsp_euclid_distance <= '0;
            end else begin
               rsp_cell_x          <= mx_ff[CELL_W-1:0];
               rsp_cell_y          <= my_ff[CELL_W-1:0];
               rsp_hit_tile_bits   <= bits_ff;
               rsp_perp_distance   <= perp_ff;
               rsp_wall_fraction   <= wall_ff[FRAC_BITS] ? WALL_MAX : wall_ff[WALL_W-1:0];
               rsp_euclid_distance <= (root_ff > ROOT_W'(DIST_MAX)) ? DIST_MAX
                                                                    : DIST_W'(root_ff);
            end
         end
         default: ;
      endcase
   end
endmodule

@@ src/grt_ctrl.sv @@
// controller: sequences clear sweep, ray stepping, divisions, root and response
module grt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output grt_pkg::dp_cmd_type   cmd,
   input  grt_pkg::dp_stat_type  stat
);
   import grt_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_SIDEX, S_SIDEY, S_STEP, S_CHECK,
      S_DIVP, S_DIVP_RUN, S_PERP, S_MUL, S_DIVC, S_DIVC_RUN, S_COORD,
      S_EXY, S_SQX, S_SQY, S_SQRT, S_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_fire, out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and datapath command
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd.op       = CMD_NONE;
      cmd.tile_wr  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: if (stat.clear_done) state_in = S_IDLE;
         S_IDLE: begin
            if (req_fire) begin
               if (req_operation == OP_CAST) begin
                  cmd.op   = CMD_INIT;
                  state_in = S_SIDEX;
               end else begin
                  cmd.tile_wr = 1'b1;
               end
            end
         end
         S_SIDEX: begin
            cmd.op   = CMD_SIDEX;
            state_in = S_SIDEY;
         end
         S_SIDEY: begin
            cmd.op   = CMD_SIDEY;
            state_in = S_STEP;
         end
         S_STEP: begin
            cmd.op   = CMD_STEP;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.op = CMD_CHECK;
            if (stat.oob) begin
               state_in = S_OUT;
            end else if (stat.hit) begin
               state_in = S_DIVP;
            end else begin
               state_in = S_STEP;
            end
         end
         S_DIVP: begin
            cmd.op   = CMD_DIV_PERP;
            cnt_in   = CNT_W'(DIV_STEPS - 1);
            state_in = S_DIVP_RUN;
         end
         S_DIVP_RUN: begin
            cmd.op = CMD_DIV_ITER;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = S_PERP;
         end
         S_PERP: begin
            cmd.op   = CMD_PERP_DONE;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op   = CMD_MUL;
            state_in = S_DIVC;
         end
         S_DIVC: begin
            cmd.op   = CMD_DIV_COORD;
            cnt_in   = CNT_W'(DIV_STEPS - 1);
            state_in = S_DIVC_RUN;
         end
         S_DIVC_RUN: begin
            cmd.op = CMD_DIV_ITER;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = S_COORD;
         end
         S_COORD: begin
            cmd.op   = CMD_COORD_DONE;
            state_in = S_EXY;
         end
         S_EXY: begin
            cmd.op   = CMD_EXY;
            state_in = S_SQX;
         end
         S_SQX: begin
            cmd.op   = CMD_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op   = CMD_SQY;
            cnt_in   = CNT_W'(SQRT_STEPS - 1);
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = CMD_SQRT_ITER;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.op       = CMD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`include "grid_ray_traversal_dda_top_macros.svh"

   `GRT_ASSERT_SAME(a_no_overwrite, cmd.op == CMD_OUT, out_free, "pending response overwritten")
   `GRT_ASSERT_SAME(a_req_after_clear, req_fire, stat.clear_done, "request taken during clear")
   `GRT_ASSERT_NEXT(a_step_then_check, state_ff == S_STEP, state_ff == S_CHECK, "step without check")
   `GRT_ASSERT_NEXT(a_out_sets_valid, cmd.op == CMD_OUT, rsp_valid_ff, "response not raised")
endmodule

@@ src/grid_ray_traversal_dda_top.sv @@
// top level of the grid ray traversal block
//
//  channel | dir | content                                   | accepted when
//  req     | in  | tile load or ray cast request             | req.valid && req.ready
//  rsp     | out | one result per ray cast                   | rsp.valid && rsp.ready
//  csr     | in  | map width (index 0), map height (index 1) | csr.valid && csr.ready
//
// after reset the tile store is cleared, all 4096 tiles in turn; no request is taken meanwhile
// a load is written to the tile store in the cycle it is taken; a cast walks the map one
// cell per step until it stops on a tile or leaves the map, at most map width plus height
// steps, each step one tile memory read and one check
// the two divisions run 42 iterations each on one shared radix-2 divider, the root 24
// a finished result waits in the response register while the next request is taken
module grid_ray_traversal_dda_top (
   input logic clock,
   input logic reset,
   grt_req_if.sink   req,
   grt_rsp_if.source rsp,
   grt_csr_if.sink   csr
);
   import grt_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr.ready = 1'b1;

   grt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_ready     (req.ready),
      .req_operation (req.operation),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .cmd           (cmd),
      .stat          (stat)
   );

   grt_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_tile_x          (req.tile_x),
      .req_tile_y          (req.tile_y),
      .req_tile_bits       (req.tile_bits),
      .req_start_x         (req.start_x),
      .req_start_y         (req.start_y),
      .req_dir_x           (req.dir_x),
      .req_dir_y           (req.dir_y),
      .req_hit_mode        (req.hit_mode),
      .csr_wr              (csr.valid && csr.ready),
      .csr_index           (csr.index),
      .csr_data            (csr.data),
      .rsp_out_of_bounds   (rsp.out_of_bounds),
      .rsp_hit_face        (rsp.hit_face),
      .rsp_cell_x          (rsp.cell_x),
      .rsp_cell_y          (rsp.cell_y),
      .rsp_hit_tile_bits   (rsp.hit_tile_bits),
      .rsp_perp_distance   (rsp.perp_distance),
      .rsp_wall_fraction   (rsp.wall_fraction),
      .rsp_euclid_distance (rsp.euclid_distance)
   );
endmodule

@@ sim/grid_ray_traversal_dda_top_tb.sv @@
// testbench of the grid ray traversal block: tile loads, ray casts and map size registers
module grid_ray_traversal_dda_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import grt_pkg::*;

   typedef struct packed {
      logic              out_of_bounds;
      logic [1:0]        hit_face;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic [TILE_W-1:0] hit_tile_bits;
      logic [DIST_W-1:0] perp_distance;
      logic [WALL_W-1:0] wall_fraction;
      logic [DIST_W-1:0] euclid_distance;
   } ray_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   grt_req_if req_ch ();
   grt_rsp_if rsp_ch ();
   grt_csr_if csr_ch ();

   grid_ray_traversal_dda_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // local copy of the block state
   logic [TILE_W-1:0] tile_map [MAP_DIM*MAP_DIM];
   logic [CFG_W-1:0]  cols_in_use;
   logic [CFG_W-1:0]  rows_in_use;

   ray_result_type expected_hits [$];
   int          error_count;
   int          rsp_hold;

   always #6 clock = ~clock;

   // hard limit on run time
   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   // walk one ray over the local map and work out its result
   function automatic ray_result_type cast_ray(logic [POS_W-1:0] pos_x,
                                               logic [POS_W-1:0] pos_y,
                                               logic signed [DIR_W-1:0] dir_x,
                                               logic signed [DIR_W-1:0] dir_y, logic mode);
      ray_result_type r;
      longint sx, sy, dx, dy, w, h, mx, my, kx, ky, fx, fy, adx, ady;
      longint lhs, rhs, num, den, perp, comp, base, coord, wall, hx, hy, ex, ey;
      longint prod, q, v, root, bitv;
      logic [TILE_W-1:0] bits;
      logic [1:0] face;
      bit xstep, done, stop_bit, tex_bit;
      r = '0;
      sx = longint'(pos_x); sy = longint'(pos_y);
      dx = longint'(dir_x); dy = longint'(dir_y);
      w = (cols_in_use > CFG_W'(MAP_DIM)) ? longint'(MAP_DIM) : longint'(cols_in_use);
      h = (rows_in_use > CFG_W'(MAP_DIM)) ? longint'(MAP_DIM) : longint'(rows_in_use);
      mx = sx >>> FRAC_BITS;
      my = sy >>> FRAC_BITS;
      fx = (dx < 0) ? (sx & 65535) : 65536 - (sx & 65535);
      fy = (dy < 0) ? (sy & 65535) : 65536 - (sy & 65535);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      kx = 0; ky = 0; bits = '0; face = FACE_N; xstep = 0; done = 0;
      while (!done) begin
         lhs = (fx + kx * 65536) * ady;
         rhs = (fy + ky * 65536) * adx;
         if (lhs < rhs) begin
            kx++;
            mx += (dx < 0) ? -1 : 1;
            face = (dx < 0) ? FACE_N : FACE_S;
            xstep = 1;
         end else begin
            ky++;
            my += (dy < 0) ? -1 : 1;
            face = (dy > 0) ? FACE_E : FACE_W;
            xstep = 0;
         end
         if (mx < 0 || my < 0 || mx >= w || my >= h) begin
            r.out_of_bounds = 1'b1;
            r.hit_face = face;
            return r;
         end
         bits = tile_map[my * MAP_DIM + mx];
         stop_bit = mode ? bits[1 + face] : bits[0];
         tex_bit = bits[5 + face];
         done = stop_bit && tex_bit;
      end
      if (xstep) begin
         num = fx + (kx - 1) * 65536; den = adx; comp = dy; base = sy;
      end else begin
         num = fy + (ky - 1) * 65536; den = ady; comp = dx; base = sx;
      end
      if (den == 0) begin
         perp = 0;
         coord = base;
      end else begin
         perp = (num <<< FRAC_BITS) / den;
         prod = num * comp;
         q = prod / den;
         if ((prod % den != 0) && (prod < 0)) q--;
         coord = base + q;
      end
      wall = 65536 - (coord & 65535);
      hx = mx * 65536; hy = my * 65536;
      if (xstep) hy += wall;
      else hx += wall;
      ex = (hx >= sx) ? hx - sx : sx - hx;
      ey = (hy >= sy) ? hy - sy : sy - hy;
      // bitwise integer square root
      v = ex * ex + ey * ey;
      root = 0;
      bitv = longint'(1) <<< 62;
      while (bitv > v) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >>> 1) + bitv;
         end else begin
            root = root >>> 1;
         end
         bitv = bitv >>> 2;
      end
      r.hit_face = face;
      r.cell_x = mx[CELL_W-1:0];
      r.cell_y = my[CELL_W-1:0];
      r.hit_tile_bits = bits;
      r.perp_distance = (perp > DIST_MAX) ? DIST_MAX : perp[DIST_W-1:0];
      r.wall_fraction = (wall > WALL_MAX) ? WALL_MAX : wall[WALL_W-1:0];
      r.euclid_distance = (root > DIST_MAX) ? DIST_MAX : root[DIST_W-1:0];
      return r;
   endfunction

   // send one request after a random gap and predict its outcome
   task automatic send_request(logic op, logic [CELL_W-1:0] tx, logic [CELL_W-1:0] ty,
                               logic [TILE_W-1:0] tbits, logic [POS_W-1:0] px,
                               logic [POS_W-1:0] py, logic signed [DIR_W-1:0] ddx,
                               logic signed [DIR_W-1:0] ddy, logic mode);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.operation <= op;
      req_ch.tile_x    <= tx;
      req_ch.tile_y    <= ty;
      req_ch.tile_bits <= tbits;
      req_ch.start_x   <= px;
      req_ch.start_y   <= py;
      req_ch.dir_x     <= ddx;
      req_ch.dir_y     <= ddy;
      req_ch.hit_mode  <= mode;
      req_ch.valid     <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (op == OP_LOAD) tile_map[ty * MAP_DIM + tx] = tbits;
      else expected_hits = {expected_hits, cast_ray(px, py, ddx, ddy, mode)};
   endtask

   task automatic load_tile(int tx, int ty, logic [TILE_W-1:0] tbits);
      send_request(OP_LOAD, CELL_W'(tx), CELL_W'(ty), tbits, POS_W'($urandom),
                   POS_W'($urandom), DIR_W'($urandom), DIR_W'($urandom), 1'($urandom));
   endtask

   task automatic cast(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                       logic signed [DIR_W-1:0] ddx, logic signed [DIR_W-1:0] ddy,
                       logic mode);
      send_request(OP_CAST, CELL_W'($urandom), CELL_W'($urandom), TILE_W'($urandom),
                   px, py, ddx, ddy, mode);
   endtask

   // let every pending result come back, then let the block settle
   task automatic drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // register write, only while idle; the caller drops valid afterwards
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      csr_ch.valid <= 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      if (idx == CSR_MAP_WIDTH) cols_in_use = value;
      else rows_in_use = value;
   endtask

   task automatic set_map_size(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
      drain();
      write_csr(CSR_MAP_WIDTH, cols);
      write_csr(CSR_MAP_HEIGHT, rows);
      csr_ch.valid <= 1'b0;
   endtask

   // corner tiles, direction extremes, zero components, ties and leaving the map
   task automatic test_geometry;
      set_map_size(7'd64, 7'd64);
      load_tile(63, 63, 9'h1FF);
      load_tile(0, 0, 9'h1FF);
      load_tile(10, 5, 9'h1FF);
      cast(22'h020000, 22'h008000, 18'sh1FFFF, 18'sh0, 1'b0);
      cast(22'h3FFFFF, 22'h3FFFFF, -18'sh20000, -18'sh20000, 1'b0);
      cast(22'h3E8000, 22'h3E8000, 18'sh10000, 18'sh10000, 1'b0);
      cast(22'h028000, 22'h0A8000, 18'sh0, -18'sh10000, 1'b1);
      cast(22'h018000, 22'h018000, -18'sh00001, -18'sh00001, 1'b0);
      cast(22'h0A8000, 22'h058000, 18'sh0, 18'sh0, 1'b0);
      cast(22'h000000, 22'h000000, 18'sh0, 18'sh0, 1'b1);
      cast(22'h028000, 22'h098000, 18'sh1FFFF, -18'sh00001, 1'b0);
      cast(22'h098000, 22'h058000, 18'sh10000, 18'sh0, 1'b1);
   endtask

   // texture versus clip stopping, and stop bits without texture
   task automatic test_hit_modes;
      load_tile(20, 20, 9'h001);
      load_tile(21, 20, 9'h1E1);
      load_tile(20, 21, 9'h05E);
      load_tile(20, 22, 9'h1FE);
      cast(22'h128000, 22'h148000, 18'sh10000, 18'sh0, 1'b0);
      cast(22'h128000, 22'h148000, 18'sh10000, 18'sh0, 1'b1);
      cast(22'h148000, 22'h128000, 18'sh0, 18'sh10000, 1'b0);
      cast(22'h148000, 22'h128000, 18'sh0, 18'sh10000, 1'b1);
      cast(22'h148000, 22'h1A8000, 18'sh0, -18'sh10000, 1'b1);
   endtask

   // map size extremes, including starts outside the active map
   task automatic test_map_size;
      set_map_size(7'd1, 7'd1);
      cast(22'h008000, 22'h008000, 18'sh4000, 18'sh1000, 1'b0);
      cast(22'h200000, 22'h200000, -18'sh4000, -18'sh1000, 1'b0);
      set_map_size(7'd127, 7'd0);
      cast(22'h008000, 22'h008000, 18'sh4000, 18'sh1000, 1'b0);
      set_map_size(7'd64, 7'd127);
      cast(22'h3F8000, 22'h3F8000, -18'sh1000, -18'sh4000, 1'b1);
   endtask

   // random loads and casts over several map sizes
   task automatic test_random;
      int phase, n, cols, rows, sel;
      logic [TILE_W-1:0] tbits;
      logic [POS_W-1:0] px, py;
      logic signed [DIR_W-1:0] ddx, ddy;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin cols = 64; rows = 64; end
            1: begin cols = 16; rows = 12; end
            2: begin cols = 127; rows = 3; end
            3: begin cols = 0; rows = 64; end
            4: begin cols = 1; rows = 1; end
            default: begin cols = $urandom_range(1, 64); rows = $urandom_range(1, 64); end
         endcase
         set_map_size(CFG_W'(cols), CFG_W'(rows));
         if (cols > 64 || cols == 0) cols = 64;
         if (rows > 64) rows = 64;
         for (n = 0; n < 200; n++) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
               tbits = TILE_W'($urandom);
               if (sel < 3) tbits[0] = 1'b1;
               if ($urandom_range(0, 9) == 0)
                  load_tile($urandom_range(0, 63), $urandom_range(0, 63), tbits);
               else
                  load_tile($urandom_range(0, cols - 1), $urandom_range(0, rows - 1), tbits);
            end else begin
               if ($urandom_range(0, 9) == 0) begin
                  px = POS_W'($urandom);
                  py = POS_W'($urandom);
               end else begin
                  px = POS_W'($urandom_range(0, cols * 65536 - 1));
                  py = POS_W'($urandom_range(0, rows * 65536 - 1));
               end
               ddx = DIR_W'($urandom);
               ddy = DIR_W'($urandom);
               case ($urandom_range(0, 9))
                  0: ddx = '0;
                  1: ddy = '0;
                  2: ddy = ddx;
                  default: ;
               endcase
               cast(px, py, ddx, ddy, 1'($urandom));
            end
         end
      end
   endtask

   // response side: random stalls and comparison with the oldest prediction
   always @(posedge clock) begin
      int hold_next;
      ray_result_type exp_r;
      hold_next = rsp_hold;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            hold_next = $urandom_range(0, 3);
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected result, none predicted", $time);
               error_count++;
            end else begin
               exp_r = expected_hits.pop_front();
               if (rsp_ch.out_of_bounds !== exp_r.out_of_bounds) begin
                  $display("%0t: out_of_bounds exp %0d got %0d", $time,
                           exp_r.out_of_bounds, rsp_ch.out_of_bounds);
                  error_count++;
               end
               if (rsp_ch.hit_face !== exp_r.hit_face) begin
                  $display("%0t: hit_face exp %0d got %0d", $time,
                           exp_r.hit_face, rsp_ch.hit_face);
                  error_count++;
               end
               if (rsp_ch.cell_x !== exp_r.cell_x) begin
                  $display("%0t: cell_x exp %0d got %0d", $time, exp_r.cell_x, rsp_ch.cell_x);
                  error_count++;
               end
               if (rsp_ch.cell_y !== exp_r.cell_y) begin
                  $display("%0t: cell_y exp %0d got %0d", $time, exp_r.cell_y, rsp_ch.cell_y);
                  error_count++;
               end
               if (rsp_ch.hit_tile_bits !== exp_r.hit_tile_bits) begin
                  $display("%0t: hit_tile_bits exp %h got %h", $time,
                           exp_r.hit_tile_bits, rsp_ch.hit_tile_bits);
                  error_count++;
               end
               if (rsp_ch.perp_distance !== exp_r.perp_distance) begin
                  $display("%0t: perp_distance exp %h got %h", $time,
                           exp_r.perp_distance, rsp_ch.perp_distance);
                  error_count++;
               end
               if (rsp_ch.wall_fraction !== exp_r.wall_fraction) begin
                  $display("%0t: wall_fraction exp %h got %h", $time,
                           exp_r.wall_fraction, rsp_ch.wall_fraction);
                  error_count++;
               end
               if (rsp_ch.euclid_distance !== exp_r.euclid_distance) begin
                  $display("%0t: euclid_distance exp %h got %h", $time,
                           exp_r.euclid_distance, rsp_ch.euclid_distance);
                  error_count++;
               end
            end
         end
         if (hold_next > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold <= hold_next - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            rsp_hold <= 0;
         end
      end
   end

   // main sequence
   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_LOAD;
      req_ch.tile_x    <= '0;
      req_ch.tile_y    <= '0;
      req_ch.tile_bits <= '0;
      req_ch.start_x   <= '0;
      req_ch.start_y   <= '0;
      req_ch.dir_x     <= '0;
      req_ch.dir_y     <= '0;
      req_ch.hit_mode  <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= CSR_MAP_WIDTH;
      csr_ch.data      <= '0;
      error_count = 0;
      rsp_hold = 0;
      cols_in_use = 7'd64;
      rows_in_use = 7'd64;
      foreach (tile_map[i]) tile_map[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_geometry();
      test_hit_modes();
      test_map_size();
      test_random();
      drain();
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
